// File: rtl/tlbc_pkg.sv
// shared types, constants and register indexes of the three-layer blend compositor
package tlbc_pkg;

  localparam int unsigned LAYERS    = 3;
  localparam int unsigned CHANNELS  = 3;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned OPAC_W    = 7;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned SUM_W     = 15;
  localparam int unsigned RECIP_W   = 16;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W + 1;
  localparam int unsigned DIV_SHIFT = 22;
  // round-up reciprocal of one hundred, exact floor for sums up to 25500
  localparam logic [RECIP_W-1:0] RECIP_100 = 16'd41944;
  localparam logic [OPAC_W-1:0]  FULL_OPAC = 7'd100;
  localparam logic [CHAN_W-1:0]  WHITE     = 8'd255;
  localparam int unsigned IN_DATA_W  = LAYERS * CHANNELS * CHAN_W;
  localparam int unsigned OUT_DATA_W = CHANNELS * CHAN_W;

  // blend modes
  localparam logic [MODE_W-1:0] MODE_NORMAL  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MUL     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DARKEN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LIGHTEN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DIFF    = 3'd4;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MODE0  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE1  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE2  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OPAC0  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OPAC1  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_OPAC2  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE = 3'd6;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [CHANNELS-1:0] rgb_t;
  typedef rgb_t [LAYERS-1:0] pix_t;

  // per-layer settings seen by a blend stage
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [OPAC_W-1:0] opac;
  } lcfg_t;

endpackage

// File: rtl/tlbc_cfg.sv
// configuration registers and effective per-layer opacity
module tlbc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tlbc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tlbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tlbc_pkg::lcfg_t [tlbc_pkg::LAYERS-1:0] lcfg
);
  import tlbc_pkg::*;

  logic [LAYERS-1:0][MODE_W-1:0] mode_r;
  logic [LAYERS-1:0][OPAC_W-1:0] opac_r;
  logic [LAYERS-1:0]             en_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      opac_r <= {LAYERS{FULL_OPAC}};
      en_r   <= '1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE0:  mode_r[0] <= cfg_wdata[MODE_W-1:0];
        REG_MODE1:  mode_r[1] <= cfg_wdata[MODE_W-1:0];
        REG_MODE2:  mode_r[2] <= cfg_wdata[MODE_W-1:0];
        REG_OPAC0:  opac_r[0] <= cfg_wdata[OPAC_W-1:0];
        REG_OPAC1:  opac_r[1] <= cfg_wdata[OPAC_W-1:0];
        REG_OPAC2:  opac_r[2] <= cfg_wdata[OPAC_W-1:0];
        REG_ENABLE: en_r      <= cfg_wdata[LAYERS-1:0];
        default: ;
      endcase
    end
  end

  // saturate opacity at one hundred; a disabled layer blends with zero opacity
  always_comb begin
    for (int k = 0; k < LAYERS; k++) begin
      lcfg[k].mode = mode_r[k];
      if (!en_r[k]) begin
        lcfg[k].opac = '0;
      end else if (opac_r[k] > FULL_OPAC) begin
        lcfg[k].opac = FULL_OPAC;
      end else begin
        lcfg[k].opac = opac_r[k];
      end
    end
  end

endmodule

// File: rtl/tlbc_layer.sv
// one layer's blend: mix stage, weighted sum stage, divide-by-hundred stage
module tlbc_layer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  tlbc_pkg::lcfg_t lcfg,
  input  logic            in_valid,
  input  tlbc_pkg::pix_t  in_pix,
  input  tlbc_pkg::rgb_t  in_top,
  input  tlbc_pkg::rgb_t  in_acc,
  output logic            out_valid,
  output tlbc_pkg::pix_t  out_pix,
  output tlbc_pkg::rgb_t  out_acc
);
  import tlbc_pkg::*;

  logic                             va_r, vb_r, vc_r;
  pix_t                             pix_a_r, pix_b_r, pix_c_r;
  rgb_t                             m_nxt, m_a_r, base_a_r;
  logic [CHANNELS-1:0][SUM_W-1:0]   sum_nxt, sum_b_r;
  rgb_t                             acc_nxt, acc_c_r;
  logic [2*CHAN_W-1:0]              mul_w [CHANNELS];
  logic [PROD_W-1:0]                div_w [CHANNELS];
  logic [OPAC_W-1:0]                inv_opac;

  // mix by mode, per channel
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      mul_w[c] = {{CHAN_W{1'b0}}, in_top[c]} * {{CHAN_W{1'b0}}, in_acc[c]};
      case (lcfg.mode)
        MODE_MUL:     m_nxt[c] = mul_w[c][2*CHAN_W-1:CHAN_W];
        MODE_DARKEN:  m_nxt[c] = (in_top[c] < in_acc[c]) ? in_top[c] : in_acc[c];
        MODE_LIGHTEN: m_nxt[c] = (in_top[c] > in_acc[c]) ? in_top[c] : in_acc[c];
        MODE_DIFF:    m_nxt[c] = (in_top[c] > in_acc[c]) ? (in_top[c] - in_acc[c])
                                                         : (in_acc[c] - in_top[c]);
        default:      m_nxt[c] = in_top[c];
      endcase
    end
  end

  // opacity weighted sum, at most 100 * 255
  assign inv_opac = FULL_OPAC - lcfg.opac;
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      sum_nxt[c] = SUM_W'(lcfg.opac) * SUM_W'(m_a_r[c])
                 + SUM_W'(inv_opac) * SUM_W'(base_a_r[c]);
    end
  end

  // floor division by one hundred via reciprocal
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      div_w[c]   = PROD_W'(sum_b_r[c]) * PROD_W'(RECIP_100);
      acc_nxt[c] = div_w[c][DIV_SHIFT+CHAN_W-1:DIV_SHIFT];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      pix_a_r  <= in_pix;
      m_a_r    <= m_nxt;
      base_a_r <= in_acc;
      pix_b_r  <= pix_a_r;
      sum_b_r  <= sum_nxt;
      pix_c_r  <= pix_b_r;
      acc_c_r  <= acc_nxt;
    end
  end

  assign out_valid = vc_r;
  assign out_pix   = pix_c_r;
  assign out_acc   = acc_c_r;

endmodule

// File: rtl/three_layer_blend_compositor_core.sv
// throughput: one pixel per clock unless the result side stalls
// each layer is a mix, sum and divide stage; a stall on the result side holds every
// stage, so nothing is lost or repeated; reset (synchronous, active low) clears all
// valid bits and loads the register defaults: normal mode, full opacity, all layers enabled
module three_layer_blend_compositor_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // first_layer r,g,b; second_layer r,g,b; third_layer r,g,b (8 bits each, from bit 0)
  input  logic [tlbc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_red, out_green, out_blue (8 bits each, from bit 0)
  output logic [tlbc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [tlbc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tlbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tlbc_pkg::*;

  lcfg_t [LAYERS-1:0] lcfg;
  logic               adv;
  logic [LAYERS:0]    v_w;
  pix_t               pix_w [LAYERS+1];
  rgb_t               acc_w [LAYERS+1];

  tlbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .lcfg      (lcfg)
  );

  // whole pipeline moves unless the result stage is full and not taken
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // pipeline entry over a white base
  assign v_w[0]   = in_tvalid;
  assign pix_w[0] = pix_t'(in_tdata);
  assign acc_w[0] = {CHANNELS{WHITE}};

  for (genvar k = 0; k < LAYERS; k++) begin : g_layer
    tlbc_layer u_layer (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .lcfg      (lcfg[k]),
      .in_valid  (v_w[k]),
      .in_pix    (pix_w[k]),
      .in_top    (pix_w[k][k]),
      .in_acc    (acc_w[k]),
      .out_valid (v_w[k+1]),
      .out_pix   (pix_w[k+1]),
      .out_acc   (acc_w[k+1])
    );
  end

  assign out_tvalid = v_w[LAYERS];
  assign out_tdata  = OUT_DATA_W'(acc_w[LAYERS]);

endmodule

// File: rtl/tlbc_checker.sv
// port-level checks on the compositor, bound to the top level
module tlbc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tlbc_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a held result keeps its value until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // input side only stalls when the result stage is full and not taken
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow result side");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // a cycle with no transfer on either side keeps the result stage valid
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && !in_tready |=> out_tvalid)
    else $error("result dropped while stalled");

endmodule

bind three_layer_blend_compositor_core tlbc_checker u_tlbc_checker (.*);
